@@ hw/rtl/rwl_pkg.sv @@
// Shared types and constants for the reader-writer lock arbiter.
package rwl_pkg;

  localparam int IdW        = 4;
  localparam int ReaderCntW = 5;
  localparam int SinceW     = 8;
  localparam int GrantCntW  = 5;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 8;

  localparam logic [ReaderCntW-1:0] ReaderCntMax = 5'd31;
  localparam logic [SinceW-1:0]     SinceMax     = 8'd255;
  localparam logic [GrantCntW-1:0]  ResultLimit  = 5'd16;

  // priority_mode codes
  localparam logic [1:0] PrioReaders = 2'd0;
  localparam logic [1:0] PrioWriters = 2'd1;
  localparam logic [1:0] PrioNWay    = 2'd2;
  localparam logic [1:0] PrioUnused  = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPriorityMode = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgNWayLimit    = 1'd1;

  typedef enum logic [1:0] {
    OpReadAcq  = 2'd0,
    OpReadRel  = 2'd1,
    OpWriteAcq = 2'd2,
    OpWriteRel = 2'd3
  } rwl_op_e;

  typedef struct packed {
    logic [1:0]     mode;
    logic [IdW-1:0] requester;
  } rwl_req_t;

  typedef struct packed {
    logic [IdW-1:0] granted_requester;
    logic           granted_kind;
    logic           last;
  } rwl_grant_t;

  typedef enum logic [2:0] {
    StIdle,
    StDecide,
    StRelSel,
    StWakeRd,
    StWakeWr,
    StEmit
  } rwl_state_e;

  typedef struct packed {
    logic capture_req;
    logic clr_grants;
    logic grant_rd_req;
    logic grant_wr_req;
    logic grant_rd_pop;
    logic grant_wr_pop;
    logic push_rd;
    logic push_wr;
    logic dec_readers;
    logic clr_writer;
    logic load_out;
    logic last;
  } rwl_cmd_t;

  typedef struct packed {
    rwl_op_e    op;
    logic [1:0] prio;
    logic       rd_blocked;
    logic       wr_blocked;
    logic       rd_waiting;
    logic       wr_waiting;
    logic       rd_full;
    logic       wr_full;
    logic       readers_active;
    logic       last_reader;
    logic       writer_holds;
    logic       since_below_limit;
    logic       grant_room;
    logic       out_free;
  } rwl_status_t;

endpackage

@@ hw/rtl/reader_writer_lock_arbiter_unit.sv @@
// Top level of the reader-writer lock arbiter.
//
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_ready_o   | in_req_i    (mode, requester)
//  out     | output    | out_valid_o / out_ready_i | out_grant_o (requester, kind, last)
//  cfg     | input     | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// A request is taken only while the sequencer is idle. An acquire passes through
// the decide step and, with a grant, the emit step; a release that wakes queued
// readers alternates wake and emit steps, one pop per reader, set by the registered
// head read of the wait queue. A stalled output holds the sequencer in its emit step.
// Reset is asynchronous; queues start empty, no clearing pass.
module reader_writer_lock_arbiter_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rwl_pkg::rwl_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rwl_pkg::rwl_grant_t           out_grant_o,
  input  logic                          cfg_we_i,
  input  logic [rwl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rwl_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  rwl_pkg::rwl_cmd_t    cmd;
  rwl_pkg::rwl_status_t status;

  rwl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rwl_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_grant_o (out_grant_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

@@ hw/rtl/rwl_fifo.sv @@
// Circular FIFO of requester ids with a registered head read.
module rwl_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [rwl_pkg::IdW-1:0]  data_i,
  input  logic                     pop_i,
  output logic [rwl_pkg::IdW-1:0]  head_o,
  output logic                     nonempty_o,
  output logic                     full_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [rwl_pkg::IdW-1:0] mem_q [DEPTH];
  logic [rwl_pkg::IdW-1:0] rd_q;
  logic [PtrW-1:0]         head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]         cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= data_i;
    end
    rd_q <= mem_q[head_q];
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      tail_d = (tail_q == PtrW'(DEPTH - 1)) ? '0 : tail_q + PtrW'(1);
      cnt_d  = cnt_q + CntW'(1);
    end else if (pop_i) begin
      head_d = (head_q == PtrW'(DEPTH - 1)) ? '0 : head_q + PtrW'(1);
      cnt_d  = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  assign head_o     = rd_q;
  assign nonempty_o = (cnt_q != '0);
  assign full_o     = (cnt_q == CntW'(DEPTH));

endmodule

@@ hw/rtl/rwl_datapath.sv @@
// Lock state, wait queues, config registers and the output register.
module rwl_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rwl_pkg::rwl_req_t             in_req_i,
  input  logic                          cfg_we_i,
  input  logic [rwl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rwl_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output rwl_pkg::rwl_grant_t           out_grant_o,
  input  rwl_pkg::rwl_cmd_t             cmd_i,
  output rwl_pkg::rwl_status_t          status_o
);

  logic [1:0]                        prio_q;
  logic [rwl_pkg::SinceW-1:0]        nlim_q;
  rwl_pkg::rwl_req_t                 req_q;
  logic [rwl_pkg::ReaderCntW-1:0]    arc_q, arc_d;
  logic                              wh_q, wh_d;
  logic [rwl_pkg::SinceW-1:0]        rsw_q, rsw_d;
  logic [rwl_pkg::GrantCntW-1:0]     gcnt_q, gcnt_d;
  logic [rwl_pkg::IdW-1:0]           pend_id_q;
  logic                              pend_kind_q;
  logic                              out_valid_q;
  rwl_pkg::rwl_grant_t               out_q;

  logic [rwl_pkg::IdW-1:0] rd_head, wr_head, grant_id;
  logic rd_waiting, wr_waiting, rd_full, wr_full;
  logic grant_rd, grant_wr, any_grant;
  logic [1:0] prio_eff;
  logic since_below, rd_blocked, wr_blocked;

  rwl_fifo #(.DEPTH(QUEUE_DEPTH)) u_rd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_i.push_rd),
    .data_i     (req_q.requester),
    .pop_i      (cmd_i.grant_rd_pop),
    .head_o     (rd_head),
    .nonempty_o (rd_waiting),
    .full_o     (rd_full)
  );

  rwl_fifo #(.DEPTH(QUEUE_DEPTH)) u_wr_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_i.push_wr),
    .data_i     (req_q.requester),
    .pop_i      (cmd_i.grant_wr_pop),
    .head_o     (wr_head),
    .nonempty_o (wr_waiting),
    .full_o     (wr_full)
  );

  // unused mode code behaves as readers first
  assign prio_eff    = (prio_q == rwl_pkg::PrioUnused) ? rwl_pkg::PrioReaders : prio_q;
  assign since_below = (rsw_q < nlim_q);

  assign rd_blocked = wh_q
                    | ((prio_eff == rwl_pkg::PrioWriters) & wr_waiting)
                    | ((prio_eff == rwl_pkg::PrioNWay) & wr_waiting & ~since_below);
  assign wr_blocked = (arc_q != '0) | wh_q
                    | ((prio_eff == rwl_pkg::PrioReaders) & rd_waiting)
                    | ((prio_eff == rwl_pkg::PrioNWay) & rd_waiting & since_below);

  assign grant_rd  = cmd_i.grant_rd_req | cmd_i.grant_rd_pop;
  assign grant_wr  = cmd_i.grant_wr_req | cmd_i.grant_wr_pop;
  assign any_grant = grant_rd | grant_wr;
  assign grant_id  = cmd_i.grant_rd_pop ? rd_head :
                     cmd_i.grant_wr_pop ? wr_head : req_q.requester;

  always_comb begin
    arc_d  = arc_q;
    wh_d   = wh_q;
    rsw_d  = rsw_q;
    gcnt_d = gcnt_q;
    if (grant_rd) begin
      if (arc_q != rwl_pkg::ReaderCntMax) arc_d = arc_q + 5'd1;
      if (rsw_q != rwl_pkg::SinceMax) rsw_d = rsw_q + 8'd1;
    end else if (cmd_i.dec_readers) begin
      arc_d = arc_q - 5'd1;
    end
    if (grant_wr) begin
      wh_d  = 1'b1;
      rsw_d = '0;
    end else if (cmd_i.clr_writer) begin
      wh_d = 1'b0;
    end
    if (cmd_i.clr_grants) begin
      gcnt_d = '0;
    end else if (any_grant) begin
      gcnt_d = gcnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q      <= rwl_pkg::PrioReaders;
      nlim_q      <= 8'd1;
      arc_q       <= '0;
      wh_q        <= 1'b0;
      rsw_q       <= '0;
      gcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          rwl_pkg::CfgPriorityMode: prio_q <= cfg_wdata_i[1:0];
          rwl_pkg::CfgNWayLimit:    nlim_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      arc_q  <= arc_d;
      wh_q   <= wh_d;
      rsw_q  <= rsw_d;
      gcnt_q <= gcnt_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_req) req_q <= in_req_i;
    if (any_grant) begin
      pend_id_q   <= grant_id;
      pend_kind_q <= grant_wr;
    end
    if (cmd_i.load_out) begin
      out_q.granted_requester <= pend_id_q;
      out_q.granted_kind      <= pend_kind_q;
      out_q.last              <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_grant_o = out_q;

  always_comb begin
    status_o.op                = rwl_pkg::rwl_op_e'(req_q.mode);
    status_o.prio              = prio_eff;
    status_o.rd_blocked        = rd_blocked;
    status_o.wr_blocked        = wr_blocked;
    status_o.rd_waiting        = rd_waiting;
    status_o.wr_waiting        = wr_waiting;
    status_o.rd_full           = rd_full;
    status_o.wr_full           = wr_full;
    status_o.readers_active    = (arc_q != '0);
    status_o.last_reader       = (arc_q == 5'd1);
    status_o.writer_holds      = wh_q;
    status_o.since_below_limit = since_below;
    status_o.grant_room        = (gcnt_q < rwl_pkg::ResultLimit);
    status_o.out_free          = ~out_valid_q | out_ready_i;
  end

`ifndef SYNTHESIS
  a_excl_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wh_q |-> (arc_q == '0))
    else $error("writer holds lock while readers are active");
  a_out_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (~out_valid_q | out_ready_i))
    else $error("output register overwritten while stalled");
  a_grant_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcnt_q <= rwl_pkg::ResultLimit)
    else $error("grant count beyond limit");
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push_rd |-> ~rd_full) and (cmd_i.push_wr |-> ~wr_full))
    else $error("push into full wait queue");
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.grant_rd_pop |-> rd_waiting) and (cmd_i.grant_wr_pop |-> wr_waiting))
    else $error("pop from empty wait queue");
`endif

endmodule

@@ hw/rtl/rwl_ctrl.sv @@
// Sequencer for the lock arbiter: decides, wakes waiters and emits grants.
module rwl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rwl_pkg::rwl_status_t  status_i,
  output rwl_pkg::rwl_cmd_t     cmd_o
);

  rwl_pkg::rwl_state_e state_q, state_d;
  logic loop_q, loop_d;
  logic rd_wake_ok, wr_wake_ok, more;

  assign rd_wake_ok = status_i.rd_waiting & ~status_i.rd_blocked & status_i.grant_room;
  assign wr_wake_ok = status_i.wr_waiting & ~status_i.wr_blocked;
  // another reader follows only inside a reader wake sweep
  assign more       = loop_q & rd_wake_ok;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rwl_pkg::StIdle: begin
        if (in_valid_i) state_d = rwl_pkg::StDecide;
      end
      rwl_pkg::StDecide: begin
        case (status_i.op)
          rwl_pkg::OpReadAcq:
            state_d = status_i.rd_blocked ? rwl_pkg::StIdle : rwl_pkg::StEmit;
          rwl_pkg::OpWriteAcq:
            state_d = status_i.wr_blocked ? rwl_pkg::StIdle : rwl_pkg::StEmit;
          rwl_pkg::OpReadRel:
            state_d = (status_i.readers_active & status_i.last_reader) ?
                      rwl_pkg::StWakeWr : rwl_pkg::StIdle;
          rwl_pkg::OpWriteRel:
            state_d = status_i.writer_holds ? rwl_pkg::StRelSel : rwl_pkg::StIdle;
          default: state_d = rwl_pkg::StIdle;
        endcase
      end
      rwl_pkg::StRelSel: begin
        case (status_i.prio)
          rwl_pkg::PrioWriters:
            state_d = status_i.wr_waiting ? rwl_pkg::StWakeWr : rwl_pkg::StWakeRd;
          rwl_pkg::PrioNWay: begin
            if (status_i.rd_waiting & status_i.since_below_limit) begin
              state_d = rwl_pkg::StWakeRd;
            end else if (status_i.wr_waiting) begin
              state_d = rwl_pkg::StWakeWr;
            end else begin
              state_d = rwl_pkg::StWakeRd;
            end
          end
          default:
            state_d = status_i.rd_waiting ? rwl_pkg::StWakeRd : rwl_pkg::StWakeWr;
        endcase
      end
      rwl_pkg::StWakeRd: state_d = rd_wake_ok ? rwl_pkg::StEmit : rwl_pkg::StIdle;
      rwl_pkg::StWakeWr: state_d = wr_wake_ok ? rwl_pkg::StEmit : rwl_pkg::StIdle;
      rwl_pkg::StEmit: begin
        if (status_i.out_free) state_d = more ? rwl_pkg::StWakeRd : rwl_pkg::StIdle;
      end
      default: state_d = rwl_pkg::StIdle;
    endcase
  end

  always_comb begin
    loop_d = loop_q;
    case (state_q)
      rwl_pkg::StDecide, rwl_pkg::StWakeWr: loop_d = 1'b0;
      rwl_pkg::StWakeRd:                    loop_d = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rwl_pkg::StIdle: begin
        in_ready_o        = 1'b1;
        cmd_o.capture_req = in_valid_i;
        cmd_o.clr_grants  = in_valid_i;
      end
      rwl_pkg::StDecide: begin
        case (status_i.op)
          rwl_pkg::OpReadAcq: begin
            cmd_o.grant_rd_req = ~status_i.rd_blocked;
            cmd_o.push_rd      = status_i.rd_blocked & ~status_i.rd_full;
          end
          rwl_pkg::OpWriteAcq: begin
            cmd_o.grant_wr_req = ~status_i.wr_blocked;
            cmd_o.push_wr      = status_i.wr_blocked & ~status_i.wr_full;
          end
          rwl_pkg::OpReadRel:  cmd_o.dec_readers = status_i.readers_active;
          rwl_pkg::OpWriteRel: cmd_o.clr_writer  = status_i.writer_holds;
          default: ;
        endcase
      end
      rwl_pkg::StWakeRd: cmd_o.grant_rd_pop = rd_wake_ok;
      rwl_pkg::StWakeWr: cmd_o.grant_wr_pop = wr_wake_ok;
      rwl_pkg::StEmit: begin
        cmd_o.load_out = status_i.out_free;
        cmd_o.last     = ~more;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rwl_pkg::StIdle;
      loop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      loop_q  <= loop_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_after_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != rwl_pkg::StEmit) && (state_d == rwl_pkg::StEmit) |->
      (cmd_o.grant_rd_req | cmd_o.grant_wr_req | cmd_o.grant_rd_pop | cmd_o.grant_wr_pop))
    else $error("emit entered without a grant");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == rwl_pkg::StDecide))
    else $error("accepted request not decided");
  a_sweep_reader: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rwl_pkg::StEmit) && status_i.out_free && more |=>
      (state_q == rwl_pkg::StWakeRd))
    else $error("reader sweep lost");
`endif

endmodule
